// ----- sv/bvws_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants of the bus voltage window supervisor.
// No dependencies.
package bvws_pkg;

   localparam int SAMPLE_W  = 12;
   localparam int LIMIT_W   = 10;
   localparam int MV_W      = 15;
   localparam int STATE_W   = 3;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;
   localparam int PROD_W    = SAMPLE_W + MV_W;

   // 17.9 * 3.3 / 2.5 V full scale, in mV, over 4096 counts
   localparam logic [MV_W-1:0] MV_SCALE = 15'd23628;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_CHG_DIS  = 3'd0;
   localparam logic [2:0] REG_CHG_RES  = 3'd1;
   localparam logic [2:0] REG_DIS_RES  = 3'd2;
   localparam logic [2:0] REG_DIS_DIS  = 3'd3;
   localparam logic [2:0] REG_PERSIST  = 3'd4;

   // supply state codes as they leave the block
   localparam logic [STATE_W-1:0] STATE_OK       = 3'd0;
   localparam logic [STATE_W-1:0] STATE_LOW_RES  = 3'd1;
   localparam logic [STATE_W-1:0] STATE_LOW_DIS  = 3'd2;
   localparam logic [STATE_W-1:0] STATE_HIGH_RES = 3'd3;
   localparam logic [STATE_W-1:0] STATE_HIGH_DIS = 3'd4;

   typedef enum logic [4:0] {
      MODE_OK       = 5'b00001,
      MODE_LOW_RES  = 5'b00010,
      MODE_LOW_DIS  = 5'b00100,
      MODE_HIGH_RES = 5'b01000,
      MODE_HIGH_DIS = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] chg_dis;
      logic [SAMPLE_W-1:0] chg_res;
      logic [SAMPLE_W-1:0] dis_res;
      logic [SAMPLE_W-1:0] dis_dis;
      logic [LIMIT_W-1:0]  persist;
   } cfg_type;

   function automatic logic [STATE_W-1:0] state_code(input mode_type mode);
      logic [STATE_W-1:0] code;
      case (mode)
         MODE_OK:       code = STATE_OK;
         MODE_LOW_RES:  code = STATE_LOW_RES;
         MODE_LOW_DIS:  code = STATE_LOW_DIS;
         MODE_HIGH_RES: code = STATE_HIGH_RES;
         MODE_HIGH_DIS: code = STATE_HIGH_DIS;
         default:       code = STATE_OK;
      endcase
      return code;
   endfunction

endpackage

// ----- sv/bvws_csr.sv -----
`timescale 1ns / 1ps
// Level and persistence registers behind the APB-style port.
// Uses bvws_pkg.
module bvws_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [bvws_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [bvws_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [bvws_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready,
   output bvws_pkg::cfg_type           cfg
);
   import bvws_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_CHG_DIS: cfg_in.chg_dis = csr_pwdata[SAMPLE_W-1:0];
            REG_CHG_RES: cfg_in.chg_res = csr_pwdata[SAMPLE_W-1:0];
            REG_DIS_RES: cfg_in.dis_res = csr_pwdata[SAMPLE_W-1:0];
            REG_DIS_DIS: cfg_in.dis_dis = csr_pwdata[SAMPLE_W-1:0];
            REG_PERSIST: cfg_in.persist = csr_pwdata[LIMIT_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_CHG_DIS: csr_prdata = CSR_DW'(cfg_ff.chg_dis);
         REG_CHG_RES: csr_prdata = CSR_DW'(cfg_ff.chg_res);
         REG_DIS_RES: csr_prdata = CSR_DW'(cfg_ff.dis_res);
         REG_DIS_DIS: csr_prdata = CSR_DW'(cfg_ff.dis_dis);
         REG_PERSIST: csr_prdata = CSR_DW'(cfg_ff.persist);
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chg_dis <= '0;
         cfg_ff.chg_res <= '0;
         cfg_ff.dis_res <= '1;
         cfg_ff.dis_dis <= '1;
         cfg_ff.persist <= LIMIT_W'(10);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- sv/bus_voltage_window_supervisor.sv -----
`timescale 1ns / 1ps
// Bus voltage window supervisor top level: sample register, state update,
// millivolt scaling and result register. Uses bvws_pkg and bvws_csr.
//
//   channel  direction  payload                                handshake
//   req      in         req_bus_sample[11:0]                   req_valid / req_stall
//   rsp      out        rsp_supply_state[2:0], rsp_bus_millivolts[14:0]  rsp_valid / rsp_stall
//   csr      in/out     APB-style, 5 registers at 4*i          csr_psel/penable/pready
//
// One word per cycle while rsp_stall is low; words pass the sample, then the result register.
// The state update and one 12x15 constant multiply sit between the sample
// register and the result register.
// Synchronous reset clears valids, supply state and both run counters.
// rsp_stall holds the result register; req_stall rises only when the sample
// register is full and the result register is full and stalled.
module bus_voltage_window_supervisor (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bvws_pkg::SAMPLE_W-1:0] req_bus_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bvws_pkg::STATE_W-1:0]  rsp_supply_state,
   output logic [bvws_pkg::MV_W-1:0]     rsp_bus_millivolts,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bvws_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [bvws_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [bvws_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import bvws_pkg::*;

   cfg_type cfg;

   logic                 smp_valid_ff, smp_valid_in;
   logic [SAMPLE_W-1:0]  smp_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATE_W-1:0]   rsp_state_ff;
   logic [MV_W-1:0]      rsp_mv_ff;
   mode_type             mode_ff, mode_in;
   logic [LIMIT_W-1:0]   low_run_ff, low_run_in;
   logic [LIMIT_W-1:0]   high_run_ff, high_run_in;
   logic [LIMIT_W:0]     low_next, high_next;
   logic [PROD_W-1:0]    product;
   logic                 advance, accept;

   bvws_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign advance   = smp_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = smp_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign smp_valid_in = accept ? 1'b1 : (advance ? 1'b0 : smp_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   assign low_next  = {1'b0, low_run_ff} + (LIMIT_W+1)'(1);
   assign high_next = {1'b0, high_run_ff} + (LIMIT_W+1)'(1);
   assign product   = PROD_W'(smp_ff) * PROD_W'(MV_SCALE);

   // priority: charge disable, charge restrict, discharge disable,
   // discharge restrict, ok. Low rules leave high_run alone and vice versa.
   always_comb begin
      mode_in     = mode_ff;
      low_run_in  = low_run_ff;
      high_run_in = high_run_ff;
      if (smp_ff <= cfg.chg_dis) begin
         if (mode_ff != MODE_LOW_DIS) begin
            if (low_next >= {1'b0, cfg.persist}) begin
               mode_in    = MODE_LOW_DIS;
               low_run_in = '0;
            end else begin
               mode_in    = MODE_LOW_RES;
               low_run_in = low_next[LIMIT_W-1:0];
            end
         end
      end else if (smp_ff <= cfg.chg_res) begin
         mode_in    = MODE_LOW_RES;
         low_run_in = '0;
      end else if (smp_ff >= cfg.dis_dis) begin
         if (mode_ff != MODE_HIGH_DIS) begin
            if (high_next >= {1'b0, cfg.persist}) begin
               mode_in     = MODE_HIGH_DIS;
               high_run_in = '0;
            end else begin
               mode_in     = MODE_HIGH_RES;
               high_run_in = high_next[LIMIT_W-1:0];
            end
         end
      end else if (smp_ff >= cfg.dis_res) begin
         mode_in     = MODE_HIGH_RES;
         high_run_in = '0;
      end else begin
         mode_in     = MODE_OK;
         low_run_in  = '0;
         high_run_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_OK;
         low_run_ff   <= '0;
         high_run_ff  <= '0;
      end else begin
         smp_valid_ff <= smp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff     <= mode_in;
            low_run_ff  <= low_run_in;
            high_run_ff <= high_run_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         smp_ff <= req_bus_sample;
      end
      if (advance) begin
         rsp_state_ff <= state_code(mode_in);
         rsp_mv_ff    <= product[PROD_W-1:SAMPLE_W];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_supply_state   = rsp_state_ff;
   assign rsp_bus_millivolts = rsp_mv_ff;

endmodule

// ----- sv/bvws_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the bus voltage window supervisor, bound to the top.
// Uses bvws_pkg.
module bvws_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [bvws_pkg::STATE_W-1:0]  rsp_supply_state,
   input logic [bvws_pkg::MV_W-1:0]     rsp_bus_millivolts
);
   import bvws_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_supply_state)
         && $stable(rsp_bus_millivolts))
      else $error("result word changed under stall");

   // input backs up only behind a full, stalled result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a stalled result");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // full-scale 4095 counts maps to 23622 mV
   a_mv_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bus_millivolts <= MV_W'(23622))
      else $error("millivolt value out of range");

   // a word may not appear without a sample having gone in
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid, 2) || $past(req_stall) || $past(req_valid, 3))
      else $error("result word without a preceding sample");

endmodule

bind bus_voltage_window_supervisor bvws_checker u_bvws_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_supply_state   (rsp_supply_state),
   .rsp_bus_millivolts (rsp_bus_millivolts)
);
